>>> sv/cram_pkg.sv
package cram_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int FRAC_BITS  = 16;

	// Cofactor, term and determinant widths, all exact
	localparam int PW  = 2 * DATA_WIDTH;
	localparam int CW  = 2 * DATA_WIDTH + 1;
	localparam int HW  = 2 * DATA_WIDTH + 1;
	localparam int TW  = 3 * DATA_WIDTH + 1;
	localparam int SW  = 3 * DATA_WIDTH + 3;
	localparam int NW  = SW + FRAC_BITS;
	localparam int QB  = DATA_WIDTH + 3;
	localparam int CMPW = SW + FRAC_BITS + DATA_WIDTH + 4;

	localparam int NTERM = 12;

	// Cofactor stages + expansion stages + divider + output register
	localparam int LATENCY = 2 + 3 + (QB + 2) + 1;

	typedef logic signed [DATA_WIDTH-1:0] elem_t;
	typedef logic signed [CW-1:0]         cof_t;
	typedef logic signed [SW-1:0]         det_t;

	typedef struct packed {
		elem_t a00;
		elem_t a01;
		elem_t a02;
		elem_t a10;
		elem_t a11;
		elem_t a12;
		elem_t a20;
		elem_t a21;
		elem_t a22;
		elem_t b0;
		elem_t b1;
		elem_t b2;
	} sys_t;

	typedef struct packed {
		elem_t x0;
		elem_t x1;
		elem_t x2;
		logic  singular;
		logic  saturated;
	} sol_t;

	typedef struct packed {
		elem_t x;
		logic  sat;
		logic  zero;
	} div_res_t;

endpackage

>>> sv/cram_cofactor.sv
module cram_cofactor
	import cram_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  sys_t  sys,
	output logic  out_valid,
	output cof_t  cof [9],
	output elem_t row0 [3],
	output elem_t rhs [3]
);

	logic signed [PW-1:0] prod_s1 [18];
	elem_t row0_s1 [3];
	elem_t rhs_s1 [3];
	logic  valid_s1;

	cof_t  cof_s2 [9];
	elem_t row0_s2 [3];
	elem_t rhs_s2 [3];
	logic  valid_s2;

	logic signed [PW-1:0] prod [18];

	// Pairs of products per cofactor C_ij = first - second
	always_comb begin
		prod[0]  = sys.a11 * sys.a22;
		prod[1]  = sys.a12 * sys.a21;
		prod[2]  = sys.a12 * sys.a20;
		prod[3]  = sys.a10 * sys.a22;
		prod[4]  = sys.a10 * sys.a21;
		prod[5]  = sys.a11 * sys.a20;
		prod[6]  = sys.a02 * sys.a21;
		prod[7]  = sys.a01 * sys.a22;
		prod[8]  = sys.a00 * sys.a22;
		prod[9]  = sys.a02 * sys.a20;
		prod[10] = sys.a01 * sys.a20;
		prod[11] = sys.a00 * sys.a21;
		prod[12] = sys.a01 * sys.a12;
		prod[13] = sys.a02 * sys.a11;
		prod[14] = sys.a02 * sys.a10;
		prod[15] = sys.a00 * sys.a12;
		prod[16] = sys.a00 * sys.a11;
		prod[17] = sys.a01 * sys.a10;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 18; i++) begin
			prod_s1[i] <= prod[i];
		end
		row0_s1[0] <= sys.a00;
		row0_s1[1] <= sys.a01;
		row0_s1[2] <= sys.a02;
		rhs_s1[0]  <= sys.b0;
		rhs_s1[1]  <= sys.b1;
		rhs_s1[2]  <= sys.b2;
		for (int i = 0; i < 9; i++) begin
			cof_s2[i] <= CW'(prod_s1[2*i]) - CW'(prod_s1[2*i+1]);
		end
		row0_s2 <= row0_s1;
		rhs_s2  <= rhs_s1;
	end

	assign out_valid = valid_s2;
	assign cof       = cof_s2;
	assign row0      = row0_s2;
	assign rhs       = rhs_s2;

endmodule

>>> sv/cram_expand.sv
module cram_expand
	import cram_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  cof_t  cof [9],
	input  elem_t row0 [3],
	input  elem_t rhs [3],
	output logic  out_valid,
	output det_t  den,
	output det_t  num [3]
);

	elem_t mul_m [NTERM];
	cof_t  mul_c [NTERM];

	logic signed [HW-1:0] lo_s3 [NTERM];
	logic signed [HW-1:0] hi_s3 [NTERM];
	logic                 valid_s3;
	logic signed [TW-1:0] term_s4 [NTERM];
	logic                 valid_s4;
	det_t                 sum_s5 [4];
	logic                 valid_s5;

	// Term 0..2: det(A) along row 0; term 3+3k+i: b_i times cofactor C_ik
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			mul_m[j] = row0[j];
			mul_c[j] = cof[j];
		end
		for (int k = 0; k < 3; k++) begin
			for (int i = 0; i < 3; i++) begin
				mul_m[3 + 3*k + i] = rhs[i];
				mul_c[3 + 3*k + i] = cof[3*i + k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s3 <= in_valid;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		for (int t = 0; t < NTERM; t++) begin
			lo_s3[t] <= mul_m[t] * $signed({1'b0, mul_c[t][DATA_WIDTH-1:0]});
			hi_s3[t] <= mul_m[t] * $signed(mul_c[t][CW-1:DATA_WIDTH]);
		end
		for (int t = 0; t < NTERM; t++) begin
			term_s4[t] <= (TW'(hi_s3[t]) <<< DATA_WIDTH) + TW'(lo_s3[t]);
		end
		for (int s = 0; s < 4; s++) begin
			sum_s5[s] <= SW'(term_s4[3*s]) + SW'(term_s4[3*s+1]) + SW'(term_s4[3*s+2]);
		end
	end

	assign out_valid = valid_s5;
	assign den       = sum_s5[0];
	assign num[0]    = sum_s5[1];
	assign num[1]    = sum_s5[2];
	assign num[2]    = sum_s5[3];

endmodule

>>> sv/cram_div.sv
module cram_div
	import cram_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  det_t     num,
	input  det_t     den,
	output logic     out_valid,
	output div_res_t res
);

	logic [SW-1:0] nabs;
	logic [SW-1:0] dabs;

	logic [NW-1:0] rem_s  [QB+1];
	logic [QB-1:0] quo_s  [QB+1];
	logic [SW-1:0] dmag_s [QB+1];
	logic          neg_s  [QB+1];
	logic          zero_s [QB+1];
	logic          valid_s [QB+1];

	div_res_t res_q;
	logic     valid_q;

	logic [DATA_WIDTH-1:0] mag;
	logic                  over;

	assign nabs = num[SW-1] ? SW'(-num) : SW'(num);
	assign dabs = den[SW-1] ? SW'(-den) : SW'(den);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s[0] <= 1'b0;
		end else begin
			valid_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		rem_s[0]  <= NW'(nabs) << FRAC_BITS;
		quo_s[0]  <= '0;
		dmag_s[0] <= dabs;
		neg_s[0]  <= num[SW-1] ^ den[SW-1];
		zero_s[0] <= (den == '0);
	end

	// One quotient bit per stage, most significant first
	for (genvar k = 0; k < QB; k++) begin : g_step
		logic [CMPW-1:0] dsh;
		logic [CMPW-1:0] rext;
		logic            ge;

		assign dsh  = CMPW'(dmag_s[k]) << (QB - 1 - k);
		assign rext = CMPW'(rem_s[k]);
		assign ge   = (rext >= dsh);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else begin
				valid_s[k+1] <= valid_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k+1]  <= ge ? NW'(rext - dsh) : rem_s[k];
			quo_s[k+1]  <= {quo_s[k][QB-2:0], ge};
			dmag_s[k+1] <= dmag_s[k];
			neg_s[k+1]  <= neg_s[k];
			zero_s[k+1] <= zero_s[k];
		end
	end

	// Top quotient bit also catches any quotient too large for the steps
	always_comb begin
		mag = quo_s[QB][DATA_WIDTH-1:0];
		if (neg_s[QB]) begin
			over = (|quo_s[QB][QB-1:DATA_WIDTH])
				|| (quo_s[QB][DATA_WIDTH-1] && (|quo_s[QB][DATA_WIDTH-2:0]));
		end else begin
			over = |quo_s[QB][QB-1:DATA_WIDTH-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_s[QB];
		end
	end

	always_ff @(posedge clk) begin
		res_q.zero <= zero_s[QB];
		if (zero_s[QB]) begin
			res_q.x   <= '0;
			res_q.sat <= 1'b0;
		end else if (over) begin
			res_q.sat <= 1'b1;
			res_q.x   <= neg_s[QB] ? {1'b1, {(DATA_WIDTH-1){1'b0}}}
				: {1'b0, {(DATA_WIDTH-1){1'b1}}};
		end else begin
			res_q.sat <= 1'b0;
			res_q.x   <= neg_s[QB] ? $signed(-mag) : $signed(mag);
		end
	end

	assign out_valid = valid_q;
	assign res       = res_q;

endmodule

>>> sv/cramer_3x3_solver_unit.sv
// Solves A*x = b for one 3x3 system per clock by Cramer's rule. All inputs and
// outputs are signed Q16.16. Pulse start with the system on sys; it is always
// taken (busy stays low). When the system reaches the output register, done
// is high for one cycle with sol valid; a new system may enter every cycle,
// and the results leave in order, one per cycle. The restoring divider spends
// one stage per quotient bit (35 stages) after a 5-stage multiply and add tree
// for the exact determinants. Quotients truncate toward zero and clip to range
// with saturated set; a zero det(A) returns zeros with singular.
module cramer_3x3_solver_unit
	import cram_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  sys_t sys,
	output logic done,
	output sol_t sol
);

	logic  cof_valid;
	cof_t  cof [9];
	elem_t row0 [3];
	elem_t rhs [3];

	logic exp_valid;
	det_t den;
	det_t num [3];

	logic     div_valid [3];
	div_res_t div_res [3];

	sol_t sol_q;
	logic done_q;

	assign busy = 1'b0;

	cram_cofactor u_cof (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start && !busy),
		.sys       (sys),
		.out_valid (cof_valid),
		.cof       (cof),
		.row0      (row0),
		.rhs       (rhs)
	);

	cram_expand u_exp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cof_valid),
		.cof       (cof),
		.row0      (row0),
		.rhs       (rhs),
		.out_valid (exp_valid),
		.den       (den),
		.num       (num)
	);

	for (genvar k = 0; k < 3; k++) begin : g_div
		cram_div u_div (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (exp_valid),
			.num       (num[k]),
			.den       (den),
			.out_valid (div_valid[k]),
			.res       (div_res[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= div_valid[0];
		end
	end

	always_ff @(posedge clk) begin
		sol_q.x0        <= div_res[0].x;
		sol_q.x1        <= div_res[1].x;
		sol_q.x2        <= div_res[2].x;
		sol_q.singular  <= div_res[0].zero;
		sol_q.saturated <= div_res[0].sat | div_res[1].sat | div_res[2].sat;
	end

	assign done = done_q;
	assign sol  = sol_q;

`ifndef ASSERT_OFF
	a_latency : assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LATENCY done)
		else $error("result transfer out of step with input transfer");

	a_sing_nosat : assert property (@(posedge clk) disable iff (!arst_n)
		done && sol.singular |-> !sol.saturated)
		else $error("singular and saturated together");

	a_sing_zero : assert property (@(posedge clk) disable iff (!arst_n)
		done && sol.singular |-> (sol.x0 == '0) && (sol.x1 == '0) && (sol.x2 == '0))
		else $error("singular result not zero");

	a_lanes : assert property (@(posedge clk) disable iff (!arst_n)
		(div_valid[0] == div_valid[1]) && (div_valid[1] == div_valid[2]))
		else $error("divider lanes out of step");
`endif

endmodule
